// File: hdl/htt_pkg.sv
// ----------------------------------------------------------------------------
// htt_pkg: shared types and constants of the hysteresis thermostat timer
// Codes for operations, bands, modes and register indexes, field widths and
// the tick-rate constants that size the on-time and report counters.
// ----------------------------------------------------------------------------
package htt_pkg;

   localparam int TICKS_PER_SECOND = 10;

   localparam int TEMP_W  = 12;
   localparam int MODE_W  = 3;
   localparam int BAND_W  = 2;
   localparam int MIN_W   = 8;
   localparam int RPS_W   = 16;
   localparam int ON_W    = 17;
   localparam int RPT_W   = 20;
   localparam int HB_W    = 4;
   localparam int IDX_W   = 3;
   localparam int CSR_W   = 16;

   localparam int ON_TICKS_PER_MIN = 60 * TICKS_PER_SECOND;
   localparam int ON_PROD_W  = MIN_W + $clog2(ON_TICKS_PER_MIN + 1);
   localparam int RPT_PROD_W = RPS_W + $clog2(TICKS_PER_SECOND + 1);

   localparam logic [ON_W-1:0]  ON_MAX  = {ON_W{1'b1}};
   localparam logic [RPT_W-1:0] RPT_MAX = {RPT_W{1'b1}};

   localparam logic [HB_W-1:0] HB_LAST = HB_W'(9);

   // operation codes
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_COMMAND = 1'b1;

   // bands
   localparam logic [BAND_W-1:0] BAND_COLD  = 2'd0;
   localparam logic [BAND_W-1:0] BAND_MILD  = 2'd1;
   localparam logic [BAND_W-1:0] BAND_HOT   = 2'd2;
   localparam logic [BAND_W-1:0] BAND_ERROR = 2'd3;

   // modes
   localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_COLD  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MILD  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_HOT   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BOOST = 3'd4;

   // register indexes
   localparam logic [IDX_W-1:0] REG_COLD_ENTER   = 3'd0;
   localparam logic [IDX_W-1:0] REG_COLD_LEAVE   = 3'd1;
   localparam logic [IDX_W-1:0] REG_HOT_LEAVE    = 3'd2;
   localparam logic [IDX_W-1:0] REG_HOT_ENTER    = 3'd3;
   localparam logic [IDX_W-1:0] REG_INTERNAL_MIN = 3'd4;
   localparam logic [IDX_W-1:0] REG_INTERNAL_MAX = 3'd5;
   localparam logic [IDX_W-1:0] REG_MAX_ON_MIN   = 3'd6;
   localparam logic [IDX_W-1:0] REG_REPORT_PER   = 3'd7;

   // reset values of the registers
   localparam logic signed [TEMP_W-1:0] RST_COLD_ENTER   = 12'sd160;
   localparam logic signed [TEMP_W-1:0] RST_COLD_LEAVE   = 12'sd176;
   localparam logic signed [TEMP_W-1:0] RST_HOT_LEAVE    = 12'sd384;
   localparam logic signed [TEMP_W-1:0] RST_HOT_ENTER    = 12'sd400;
   localparam logic signed [TEMP_W-1:0] RST_INTERNAL_MIN = -12'sd160;
   localparam logic signed [TEMP_W-1:0] RST_INTERNAL_MAX = 12'sd1120;
   localparam logic [MIN_W-1:0]         RST_MAX_ON_MIN   = 8'd45;
   localparam logic [RPS_W-1:0]         RST_REPORT_PER   = 16'd30;

   typedef struct packed {
      logic signed [TEMP_W-1:0] cold_enter;
      logic signed [TEMP_W-1:0] cold_leave;
      logic signed [TEMP_W-1:0] hot_leave;
      logic signed [TEMP_W-1:0] hot_enter;
      logic signed [TEMP_W-1:0] internal_min;
      logic signed [TEMP_W-1:0] internal_max;
      logic [MIN_W-1:0]         max_on_minutes;
      logic [RPS_W-1:0]         report_period_s;
   } cfg_type;

   typedef struct packed {
      logic                     operation;
      logic signed [TEMP_W-1:0] room_temp;
      logic signed [TEMP_W-1:0] board_temp;
      logic                     link_up;
      logic [MODE_W-1:0]        mode_code;
      logic [MIN_W-1:0]         minutes;
   } item_type;

   typedef struct packed {
      logic              heater_on;
      logic [BAND_W-1:0] band;
      logic [MODE_W-1:0] mode;
      logic              heartbeat_led;
      logic              report_request;
      logic              command_accepted;
      logic [ON_W-1:0]   on_ticks_left;
   } result_type;

   // report period in ticks, saturated to the counter width
   function automatic logic [RPT_W-1:0] report_reload(input logic [RPS_W-1:0] period_s);
      logic [RPT_PROD_W-1:0] prod;
      prod = RPT_PROD_W'(period_s) * RPT_PROD_W'(TICKS_PER_SECOND);
      if (prod > RPT_PROD_W'(RPT_MAX)) begin
         return RPT_MAX;
      end
      return RPT_W'(prod);
   endfunction

   // on-time in ticks, saturated to the countdown width
   function automatic logic [ON_W-1:0] on_ticks(input logic [MIN_W-1:0] mins);
      logic [ON_PROD_W-1:0] prod;
      prod = ON_PROD_W'(mins) * ON_PROD_W'(ON_TICKS_PER_MIN);
      if (prod > ON_PROD_W'(ON_MAX)) begin
         return ON_MAX;
      end
      return ON_W'(prod);
   endfunction

endpackage

// File: hdl/htt_cfg.sv
// ----------------------------------------------------------------------------
// htt_cfg: configuration register file
// Holds the thresholds, the minute limit and the report period.
// ----------------------------------------------------------------------------
module htt_cfg
   import htt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_data,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_COLD_ENTER:   cfg_in.cold_enter      = signed'(csr_data[TEMP_W-1:0]);
            REG_COLD_LEAVE:   cfg_in.cold_leave      = signed'(csr_data[TEMP_W-1:0]);
            REG_HOT_LEAVE:    cfg_in.hot_leave       = signed'(csr_data[TEMP_W-1:0]);
            REG_HOT_ENTER:    cfg_in.hot_enter       = signed'(csr_data[TEMP_W-1:0]);
            REG_INTERNAL_MIN: cfg_in.internal_min    = signed'(csr_data[TEMP_W-1:0]);
            REG_INTERNAL_MAX: cfg_in.internal_max    = signed'(csr_data[TEMP_W-1:0]);
            REG_MAX_ON_MIN:   cfg_in.max_on_minutes  = csr_data[MIN_W-1:0];
            REG_REPORT_PER:   cfg_in.report_period_s = csr_data[RPS_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cold_enter      <= RST_COLD_ENTER;
         cfg_ff.cold_leave      <= RST_COLD_LEAVE;
         cfg_ff.hot_leave       <= RST_HOT_LEAVE;
         cfg_ff.hot_enter       <= RST_HOT_ENTER;
         cfg_ff.internal_min    <= RST_INTERNAL_MIN;
         cfg_ff.internal_max    <= RST_INTERNAL_MAX;
         cfg_ff.max_on_minutes  <= RST_MAX_ON_MIN;
         cfg_ff.report_period_s <= RST_REPORT_PER;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/htt_core.sv
// ----------------------------------------------------------------------------
// htt_core: thermostat state and per-item update
// Holds band, mode, countdowns, heater level and heartbeat count; computes
// the result of one item and commits the new state when the item advances.
// ----------------------------------------------------------------------------
module htt_core
   import htt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  item_type   item,
   output result_type result
);

   logic [BAND_W-1:0] band_ff, band_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [ON_W-1:0]   on_cnt_ff, on_cnt_in;
   logic              heater_ff, heater_in;
   logic [HB_W-1:0]   hb_cnt_ff, hb_cnt_in;
   logic [RPT_W-1:0]  rpt_cnt_ff, rpt_cnt_in;

   logic              bad;
   logic              heat;
   logic              changed;
   logic              accept_cmd;
   logic              led;

   always_comb begin
      band_in    = band_ff;
      mode_in    = mode_ff;
      on_cnt_in  = on_cnt_ff;
      heater_in  = heater_ff;
      hb_cnt_in  = hb_cnt_ff;
      rpt_cnt_in = rpt_cnt_ff;
      changed    = 1'b0;
      accept_cmd = 1'b0;
      heat       = 1'b0;
      led        = (hb_cnt_ff == HB_W'(1));
      bad        = (item.board_temp < cfg.internal_min) ||
                   (item.board_temp > cfg.internal_max);

      if (item.operation == OP_TICK) begin
         // band hysteresis
         case (band_ff)
            BAND_COLD: begin
               if (item.room_temp > cfg.cold_leave) begin
                  band_in = BAND_MILD;
                  changed = 1'b1;
               end
            end
            BAND_HOT: begin
               if (item.room_temp < cfg.hot_leave) begin
                  band_in = BAND_MILD;
                  changed = 1'b1;
               end
            end
            BAND_MILD: begin
               if (item.room_temp > cfg.hot_enter) begin
                  band_in = BAND_HOT;
                  changed = 1'b1;
               end else if (item.room_temp < cfg.cold_enter) begin
                  band_in = BAND_COLD;
                  changed = 1'b1;
               end
            end
            default: begin
               if (!bad) begin
                  band_in = BAND_HOT;
                  changed = 1'b1;
               end
            end
         endcase

         // on-time expiry
         if (on_cnt_ff != '0) begin
            on_cnt_in = on_cnt_ff - ON_W'(1);
         end
         if (on_cnt_in == '0 && mode_ff != MODE_IDLE) begin
            mode_in = MODE_IDLE;
            changed = 1'b1;
         end

         // board out of range overrides everything
         if (bad) begin
            if (band_in != BAND_ERROR) begin
               changed = 1'b1;
            end
            band_in   = BAND_ERROR;
            on_cnt_in = '0;
            mode_in   = MODE_IDLE;
         end

         case (mode_in)
            MODE_COLD:  heat = (band_in == BAND_COLD);
            MODE_MILD:  heat = (band_in <= BAND_MILD);
            MODE_HOT:   heat = (band_in <= BAND_HOT);
            MODE_BOOST: heat = (band_in <= BAND_HOT);
            default:    heat = 1'b0;
         endcase
         if (heat != heater_ff) begin
            heater_in = heat;
            changed   = 1'b1;
         end

         // heartbeat
         led = (hb_cnt_ff == '0);
         if ((hb_cnt_ff != '0 && !item.link_up) || hb_cnt_ff >= HB_LAST) begin
            hb_cnt_in = '0;
         end else begin
            hb_cnt_in = hb_cnt_ff + HB_W'(1);
         end

         // report timer
         if (rpt_cnt_ff <= RPT_W'(1)) begin
            changed    = 1'b1;
            rpt_cnt_in = report_reload(cfg.report_period_s);
         end else begin
            rpt_cnt_in = rpt_cnt_ff - RPT_W'(1);
         end
      end else begin
         // mode command: boost lock, minute limit, unknown codes
         if (item.minutes <= cfg.max_on_minutes) begin
            if (item.mode_code == MODE_BOOST || item.mode_code == MODE_IDLE) begin
               accept_cmd = 1'b1;
            end else if (mode_ff == MODE_BOOST) begin
               accept_cmd = 1'b0;
            end else if (item.mode_code == MODE_COLD || item.mode_code == MODE_MILD ||
                         item.mode_code == MODE_HOT) begin
               accept_cmd = 1'b1;
            end
         end
         if (accept_cmd) begin
            mode_in    = item.mode_code;
            on_cnt_in  = (item.mode_code == MODE_IDLE) ? '0 : on_ticks(item.minutes);
            rpt_cnt_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff    <= BAND_MILD;
         mode_ff    <= MODE_IDLE;
         on_cnt_ff  <= '0;
         heater_ff  <= 1'b0;
         hb_cnt_ff  <= '0;
         rpt_cnt_ff <= report_reload(RST_REPORT_PER);
      end else if (step) begin
         band_ff    <= band_in;
         mode_ff    <= mode_in;
         on_cnt_ff  <= on_cnt_in;
         heater_ff  <= heater_in;
         hb_cnt_ff  <= hb_cnt_in;
         rpt_cnt_ff <= rpt_cnt_in;
      end
   end

   always_comb begin
      result.heater_on        = heater_in;
      result.band             = band_in;
      result.mode             = mode_in;
      result.heartbeat_led    = led;
      result.report_request   = changed;
      result.command_accepted = accept_cmd;
      result.on_ticks_left    = on_cnt_in;
   end

endmodule

// File: hdl/hysteresis_thermostat_timer.sv
// ----------------------------------------------------------------------------
// hysteresis_thermostat_timer: thermostat with on-time limit and report timer
// Each item is a 100 ms tick or a mode command; each item gives one result.
// ----------------------------------------------------------------------------
// An item is caught in an input register at the edge that accepts it; at the
// first edge on which the result slot is free or being emptied it passes
// through the band/mode/timer update in htt_core, the thermostat state is
// committed and the result lands in the result register. The block takes one
// item in every cycle while results are taken. A result that is not taken
// holds the item behind it in the input register; the input side stalls only
// when both registers hold items and the result is not taken, so at most two
// items are in flight. A tick runs the band hysteresis, on-time expiry,
// board-temperature override, heater drive, heartbeat and report timer; a
// command applies the boost lock, minute limit and code check and, when it is
// accepted, reloads the on-time countdown and clears the report timer. The
// csr_ port writes one register per enabled edge; write it only while no item
// is in flight.
// ----------------------------------------------------------------------------
module hysteresis_thermostat_timer
   import htt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     csr_write,
   input  logic [IDX_W-1:0]         csr_index,
   input  logic [CSR_W-1:0]         csr_data,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_operation,
   input  logic signed [TEMP_W-1:0] req_room_temp,
   input  logic signed [TEMP_W-1:0] req_board_temp,
   input  logic                     req_link_up,
   input  logic [MODE_W-1:0]        req_mode_code,
   input  logic [MIN_W-1:0]         req_minutes,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_heater_on,
   output logic [BAND_W-1:0]        rsp_band,
   output logic [MODE_W-1:0]        rsp_mode,
   output logic                     rsp_heartbeat_led,
   output logic                     rsp_report_request,
   output logic                     rsp_command_accepted,
   output logic [ON_W-1:0]          rsp_on_ticks_left
);

   cfg_type    cfg;
   item_type   in_item_ff;
   logic       in_valid_ff, in_valid_in;
   result_type rsp_ff;
   result_type core_result;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;

   htt_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   htt_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (advance),
      .item   (in_item_ff),
      .result (core_result)
   );

   // advance the held item whenever the result slot is free or being emptied
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // capture a new item whenever the input side is not stalled
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_item_ff.operation  <= req_operation;
         in_item_ff.room_temp  <= req_room_temp;
         in_item_ff.board_temp <= req_board_temp;
         in_item_ff.link_up    <= req_link_up;
         in_item_ff.mode_code  <= req_mode_code;
         in_item_ff.minutes    <= req_minutes;
      end
   end

   // hold the result until it is taken
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_heater_on        = rsp_ff.heater_on;
   assign rsp_band             = rsp_ff.band;
   assign rsp_mode             = rsp_ff.mode;
   assign rsp_heartbeat_led    = rsp_ff.heartbeat_led;
   assign rsp_report_request   = rsp_ff.report_request;
   assign rsp_command_accepted = rsp_ff.command_accepted;
   assign rsp_on_ticks_left    = rsp_ff.on_ticks_left;

   // an item that advances always shows up as a valid result next cycle
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced item did not reach the result register");

   // the error band always drops the heater
   a_error_no_heat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.heater_on && rsp_ff.band == BAND_ERROR))
      else $error("heater on in error band");

   // an accepted command never carries a report request
   a_cmd_no_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.command_accepted |-> !rsp_ff.report_request)
      else $error("command result raised a report request");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the hysteresis thermostat timer
// A short table of directed ticks and commands runs under the reset settings,
// then five register settings each get a burst of random ticks and commands.
// Every status item that comes back is compared field by field against a
// predictor kept in step with each accepted item or a directed row's typed values.
// ----------------------------------------------------------------------------
module tb_top;
   import htt_pkg::*;

   localparam int TEMP_LO        = -2048;
   localparam int TEMP_HI        = 2047;
   localparam int HEARTBEAT_TOP  = 9;
   localparam int ON_CAP         = (1 << ON_W) - 1;
   localparam int REPORT_CAP     = (1 << RPT_W) - 1;
   localparam int MINUTES_TOP    = (1 << MIN_W) - 1;
   localparam logic [MODE_W-1:0] MODE_BAD = {MODE_W{1'b1}};  // undefined mode code
   localparam int NUM_ROWS       = 25;
   localparam int PHASE_ITEMS    = 115;
   localparam int FLOOD_ITEMS    = 30;
   localparam int LONG_HOLD      = 64;
   localparam int DRAIN_CYCLES   = 4;    // extra margin once the expected queue is empty
   localparam int PRINT_CAP      = 100;
   localparam int TIMEOUT_NS     = 2_000_000;

   // ---------------------------------------------------------------------
   // DUT signals, inputs driven to known values from time zero
   // ---------------------------------------------------------------------
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_write = 1'b0;
   logic [IDX_W-1:0]         csr_index = '0;
   logic [CSR_W-1:0]         csr_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_operation = OP_TICK;
   logic signed [TEMP_W-1:0] req_room_temp = '0;
   logic signed [TEMP_W-1:0] req_board_temp = '0;
   logic                     req_link_up = 1'b0;
   logic [MODE_W-1:0]        req_mode_code = MODE_IDLE;
   logic [MIN_W-1:0]         req_minutes = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_heater_on;
   logic [BAND_W-1:0]        rsp_band;
   logic [MODE_W-1:0]        rsp_mode;
   logic                     rsp_heartbeat_led;
   logic                     rsp_report_request;
   logic                     rsp_command_accepted;
   logic [ON_W-1:0]          rsp_on_ticks_left;

   hysteresis_thermostat_timer u_top (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: thermostat registers and settings as the DUT holds them
   // ---------------------------------------------------------------------
   logic [BAND_W-1:0] band_now;
   logic [MODE_W-1:0] mode_now;
   logic [ON_W-1:0]   on_left;
   logic              heater_now;
   int                beat_count;
   int                report_left;
   int cold_in, cold_out, hot_out, hot_in, board_lo, board_hi, on_limit, period_s;

   result_type due_status[$];   // predicted status items, oldest first
   int  error_count = 0;
   int  tx_idle_max = 3;
   int  rx_idle_max = 3;
   bit  flood_on = 1'b0;
   bit  long_hold_done = 1'b0;

   // ---------------------------------------------------------------------
   // Directed table; typed expectations only where obvious at a glance
   // ---------------------------------------------------------------------
   typedef struct {
      logic              op;
      int                room;
      int                board;
      logic              link;
      logic [MODE_W-1:0] code;
      int                mins;
      bit                typed;
      logic              w_heat;
      logic [BAND_W-1:0] w_band;
      logic [MODE_W-1:0] w_mode;
      logic              w_led;
      logic              w_req;
      logic              w_acc;
      int                w_on;
   } stim_type;

   stim_type directed_rows [NUM_ROWS] = '{
      // first tick after reset: mild, off, heartbeat lit, timer still far away
      '{OP_TICK,     300,     0, 1'b1, MODE_IDLE,  0, 1'b1,
        1'b0, BAND_MILD, MODE_IDLE, 1'b1, 1'b0, 1'b0, 0},
      // undefined mode code is rejected
      '{OP_COMMAND,    0,     0, 1'b0, MODE_BAD,   0, 1'b1,
        1'b0, BAND_MILD, MODE_IDLE, 1'b1, 1'b0, 1'b0, 0},
      // one minute over the limit is rejected
      '{OP_COMMAND,    0,     0, 1'b0, MODE_MILD, 46, 1'b1,
        1'b0, BAND_MILD, MODE_IDLE, 1'b1, 1'b0, 1'b0, 0},
      // exactly at the limit: full on-time loaded
      '{OP_COMMAND,    0,     0, 1'b0, MODE_MILD, 45, 1'b1,
        1'b0, BAND_MILD, MODE_MILD, 1'b1, 1'b0, 1'b1, 27000},
      // heater comes on, countdown steps, forced report after the command
      '{OP_TICK,     300,     0, 1'b1, MODE_IDLE,  0, 1'b1,
        1'b1, BAND_MILD, MODE_MILD, 1'b0, 1'b1, 1'b0, 26999},
      '{OP_TICK,   TEMP_LO,   0, 1'b1, MODE_IDLE,  0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0},
      '{OP_TICK,   TEMP_HI,   0, 1'b0, MODE_IDLE,  0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0},
      '{OP_TICK,   TEMP_HI,   0, 1'b1, MODE_IDLE,  0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0},
      '{OP_COMMAND,    0,     0, 1'b0, MODE_BOOST, 0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0},
      // boost lock holds out a band mode
      '{OP_COMMAND,    0,     0, 1'b0, MODE_COLD, 10, 1'b1,
        1'b0, BAND_HOT, MODE_BOOST, 1'b1, 1'b0, 1'b0, 0},
      // board too hot: error band, mode dropped
      '{OP_TICK,   TEMP_HI, TEMP_HI, 1'b1, MODE_IDLE, 0, 1'b1,
        1'b0, BAND_ERROR, MODE_IDLE, 1'b0, 1'b1, 1'b0, 0},
      '{OP_TICK,       0, TEMP_LO, 1'b1, MODE_IDLE, 0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0},
      '{OP_TICK,       0,  1120, 1'b1, MODE_IDLE,  0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0},
      '{OP_TICK,       0,  -160, 1'b1, MODE_IDLE,  0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0},
      '{OP_COMMAND,    0,     0, 1'b0, MODE_IDLE, MINUTES_TOP, 1'b0,
        1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0},
      '{OP_COMMAND,    0,     0, 1'b0, MODE_IDLE,  0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0},
      '{OP_COMMAND,    0,     0, 1'b0, MODE_COLD,  0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0},
      '{OP_TICK,       0,     0, 1'b1, MODE_IDLE,  0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0},
      '{OP_COMMAND,    0,     0, 1'b0, MODE_HOT,   1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0},
      '{OP_TICK,   TEMP_HI,   0, 1'b1, MODE_IDLE,  0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0},
      '{OP_COMMAND,    0,     0, 1'b0, MODE_BOOST, 45, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0},
      '{OP_COMMAND,    0,     0, 1'b0, MODE_IDLE, 45, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0},
      '{OP_TICK,       0,  -161, 1'b1, MODE_IDLE,  0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0},
      '{OP_TICK,       0,  1121, 1'b0, MODE_IDLE,  0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0},
      '{OP_TICK,       0,     0, 1'b1, MODE_IDLE,  0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0}
   };

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic int report_span();
      int t;
      t = period_s * TICKS_PER_SECOND;
      return (t > REPORT_CAP) ? REPORT_CAP : t;
   endfunction

   // Advance the thermostat by one item and return the status it produces.
   function automatic result_type thermostat_step(input item_type it);
      result_type r;
      int   room, board, t;
      logic bad, changed, heat, led, taken;
      r = '0;
      changed = 1'b0;
      taken = 1'b0;
      if (it.operation == OP_TICK) begin
         room  = $signed(it.room_temp);
         board = $signed(it.board_temp);
         bad   = (board < board_lo) || (board > board_hi);
         // hysteresis: leave a band only past its own threshold
         case (band_now)
            BAND_COLD: begin
               if (room > cold_out) begin band_now = BAND_MILD; changed = 1'b1; end
            end
            BAND_HOT: begin
               if (room < hot_out) begin band_now = BAND_MILD; changed = 1'b1; end
            end
            BAND_MILD: begin
               if (room > hot_in) begin
                  band_now = BAND_HOT;
                  changed = 1'b1;
               end else if (room < cold_in) begin
                  band_now = BAND_COLD;
                  changed = 1'b1;
               end
            end
            default: begin
               // leave the error band through hot once the board is back in range
               if (!bad) begin band_now = BAND_HOT; changed = 1'b1; end
            end
         endcase
         // count the on-time down, drop the mode when it runs out
         if (on_left != 0) on_left = on_left - 1'b1;
         if (on_left == 0 && mode_now != MODE_IDLE) begin
            mode_now = MODE_IDLE;
            changed = 1'b1;
         end
         // board out of range overrides everything
         if (bad) begin
            if (band_now != BAND_ERROR) changed = 1'b1;
            band_now = BAND_ERROR;
            on_left = '0;
            mode_now = MODE_IDLE;
         end
         case (mode_now)
            MODE_COLD:             heat = (band_now == BAND_COLD);
            MODE_MILD:             heat = (band_now <= BAND_MILD);
            MODE_HOT, MODE_BOOST:  heat = (band_now <= BAND_HOT);
            default:               heat = 1'b0;
         endcase
         if (heat != heater_now) begin
            heater_now = heat;
            changed = 1'b1;
         end
         led = (beat_count == 0);
         if (beat_count > 0 && !it.link_up) beat_count = 0;
         else if (beat_count >= HEARTBEAT_TOP) beat_count = 0;
         else beat_count++;
         if (report_left <= 1) begin
            changed = 1'b1;
            report_left = report_span();
         end else begin
            report_left--;
         end
      end else begin
         if (int'(it.minutes) <= on_limit) begin
            if (it.mode_code == MODE_BOOST || it.mode_code == MODE_IDLE) taken = 1'b1;
            else if (mode_now != MODE_BOOST && it.mode_code >= MODE_COLD &&
                     it.mode_code <= MODE_HOT) taken = 1'b1;
         end
         if (taken) begin
            mode_now = it.mode_code;
            t = int'(it.minutes) * 60 * TICKS_PER_SECOND;
            on_left = (mode_now == MODE_IDLE) ? '0 : ON_W'((t > ON_CAP) ? ON_CAP : t);
            report_left = 0;
         end
         led = (beat_count == 1);
      end
      r.heater_on        = heater_now;
      r.band             = band_now;
      r.mode             = mode_now;
      r.heartbeat_led    = led;
      r.report_request   = changed;
      r.command_accepted = taken;
      r.on_ticks_left    = on_left;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Random stimulus helpers
   // ---------------------------------------------------------------------
   function automatic int near(input int centre);
      int v;
      v = centre + int'($urandom_range(0, 16)) - 8;
      if (v < TEMP_LO) v = TEMP_LO;
      if (v > TEMP_HI) v = TEMP_HI;
      return v;
   endfunction

   // Mostly ticks around the band thresholds with the board in range; some
   // commands, a share of them invalid, with minute counts biased to zero and the limit.
   function automatic item_type random_item();
      item_type it;
      int room, board, mins;
      it.operation = ($urandom_range(0, 5) == 0) ? OP_COMMAND : OP_TICK;
      it.link_up   = ($urandom_range(0, 7) != 0);
      if (it.operation == OP_COMMAND) begin
         room  = int'($urandom_range(0, 4095)) + TEMP_LO;
         board = int'($urandom_range(0, 4095)) + TEMP_LO;
         it.mode_code = ($urandom_range(0, 7) == 0) ?
                        MODE_W'($urandom_range(MODE_BOOST + 1, MODE_BAD)) :
                        MODE_W'($urandom_range(MODE_IDLE, MODE_BOOST));
         case ($urandom_range(0, 3))
            0:       mins = 0;
            1:       mins = $urandom_range(0, on_limit);
            2:       mins = $urandom_range(0, MINUTES_TOP);
            default: mins = on_limit + int'($urandom_range(0, 1));
         endcase
         it.minutes = MIN_W'(mins);
      end else begin
         case ($urandom_range(0, 7))
            0:       room = int'($urandom_range(0, 4095)) + TEMP_LO;
            1:       room = ($urandom_range(0, 1) != 0) ? TEMP_HI : TEMP_LO;
            default: begin
               case ($urandom_range(0, 3))
                  0:       room = near(cold_in);
                  1:       room = near(cold_out);
                  2:       room = near(hot_out);
                  default: room = near(hot_in);
               endcase
            end
         endcase
         case ($urandom_range(0, 11))
            0:       board = int'($urandom_range(0, 4095)) + TEMP_LO;
            1:       board = near(board_lo);
            2:       board = near(board_hi);
            default: board = (board_lo <= board_hi) ?
                             board_lo + int'($urandom_range(0, board_hi - board_lo)) :
                             int'($urandom_range(0, 4095)) + TEMP_LO;
         endcase
         it.mode_code = MODE_W'($urandom_range(0, MODE_BAD));
         it.minutes   = MIN_W'($urandom_range(0, MINUTES_TOP));
      end
      it.room_temp  = TEMP_W'(room);
      it.board_temp = TEMP_W'(board);
      return it;
   endfunction

   // ---------------------------------------------------------------------
   // Driving and checking
   // ---------------------------------------------------------------------
   task automatic log_error(input string msg);
      error_count++;
      // keep the log readable when the DUT is badly broken
      if (error_count <= PRINT_CAP) $display("ERROR %0t: %s", $time, msg);
   endtask

   // Offer one item after a random gap, hold it until taken, then predict.
   task automatic offer(input item_type it, input bit typed, input result_type want);
      int gap;
      result_type predicted;
      gap = flood_on ? 0 : $urandom_range(0, tx_idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= it.operation;
      req_room_temp  <= it.room_temp;
      req_board_temp <= it.board_temp;
      req_link_up    <= it.link_up;
      req_mode_code  <= it.mode_code;
      req_minutes    <= it.minutes;
      do @(posedge clock); while (req_stall);
      predicted = thermostat_step(it);
      due_status.push_back(typed ? want : predicted);
   endtask

   // Drop valid and wait for the pipeline to empty.
   task automatic settle();
      req_valid <= 1'b0;
      while (due_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_W'(value);
      @(posedge clock);
   endtask

   // Write all eight registers and mirror them in the predictor.
   task automatic configure(input int ce, input int cl, input int hl, input int he,
                            input int lo, input int hi, input int mo, input int per);
      write_reg(REG_COLD_ENTER,   ce);
      write_reg(REG_COLD_LEAVE,   cl);
      write_reg(REG_HOT_LEAVE,    hl);
      write_reg(REG_HOT_ENTER,    he);
      write_reg(REG_INTERNAL_MIN, lo);
      write_reg(REG_INTERNAL_MAX, hi);
      write_reg(REG_MAX_ON_MIN,   mo);
      write_reg(REG_REPORT_PER,   per);
      csr_write <= 1'b0;
      cold_in  = ce;
      cold_out = cl;
      hot_out  = hl;
      hot_in   = he;
      board_lo = lo;
      board_hi = hi;
      on_limit = mo;
      period_s = per;
   endtask

   task automatic check_status();
      result_type want;
      if (due_status.size() == 0) begin
         log_error("status item with nothing expected");
         return;
      end
      want = due_status.pop_front();
      if (rsp_heater_on !== want.heater_on)
         log_error($sformatf("heater_on got %0d want %0d", rsp_heater_on, want.heater_on));
      if (rsp_band !== want.band)
         log_error($sformatf("band got %0d want %0d", rsp_band, want.band));
      if (rsp_mode !== want.mode)
         log_error($sformatf("mode got %0d want %0d", rsp_mode, want.mode));
      if (rsp_heartbeat_led !== want.heartbeat_led)
         log_error($sformatf("heartbeat_led got %0d want %0d",
                             rsp_heartbeat_led, want.heartbeat_led));
      if (rsp_report_request !== want.report_request)
         log_error($sformatf("report_request got %0d want %0d",
                             rsp_report_request, want.report_request));
      if (rsp_command_accepted !== want.command_accepted)
         log_error($sformatf("command_accepted got %0d want %0d",
                             rsp_command_accepted, want.command_accepted));
      if (rsp_on_ticks_left !== want.on_ticks_left)
         log_error($sformatf("on_ticks_left got %0d want %0d",
                             rsp_on_ticks_left, want.on_ticks_left));
   endtask

   // ---------------------------------------------------------------------
   // Status sink: take an item, then stall for a random count of cycles.
   // During the flood, hold off once for a long stretch so the pipeline
   // fills and the input side has to stall.
   // ---------------------------------------------------------------------
   initial begin : status_sink
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            check_status();
            if (flood_on && !long_hold_done) begin
               hold = LONG_HOLD;
               long_hold_done = 1'b1;
            end else begin
               hold = $urandom_range(0, rx_idle_max);
            end
         end else if (hold > 0) begin
            hold--;
         end
         rsp_stall <= (hold > 0);
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      stim_type   row;
      item_type   it;
      result_type want;
      int ph, n, ce, cl, hl, he;

      // predictor starts from the reset state and reset settings
      cold_in  = RST_COLD_ENTER;
      cold_out = RST_COLD_LEAVE;
      hot_out  = RST_HOT_LEAVE;
      hot_in   = RST_HOT_ENTER;
      board_lo = RST_INTERNAL_MIN;
      board_hi = RST_INTERNAL_MAX;
      on_limit = RST_MAX_ON_MIN;
      period_s = RST_REPORT_PER;
      band_now    = BAND_MILD;
      mode_now    = MODE_IDLE;
      on_left     = '0;
      heater_now  = 1'b0;
      beat_count  = 0;
      report_left = report_span();

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table under the reset settings
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         it = '0;
         it.operation  = row.op;
         it.room_temp  = TEMP_W'(row.room);
         it.board_temp = TEMP_W'(row.board);
         it.link_up    = row.link;
         it.mode_code  = row.code;
         it.minutes    = MIN_W'(row.mins);
         want = '0;
         want.heater_on        = row.w_heat;
         want.band             = row.w_band;
         want.mode             = row.w_mode;
         want.heartbeat_led    = row.w_led;
         want.report_request   = row.w_req;
         want.command_accepted = row.w_acc;
         want.on_ticks_left    = ON_W'(row.w_on);
         offer(it, row.typed, want);
      end

      // random phases, each under its own settings, written while idle
      for (ph = 1; ph <= 5; ph++) begin
         settle();
         case (ph)
            1: configure(RST_COLD_ENTER, RST_COLD_LEAVE, RST_HOT_LEAVE, RST_HOT_ENTER,
                         RST_INTERNAL_MIN, RST_INTERNAL_MAX, 180, 1);
            2: configure(TEMP_LO, TEMP_LO, TEMP_LO, TEMP_LO, TEMP_LO, TEMP_HI, 1, 65535);
            3: configure(TEMP_HI, TEMP_HI, TEMP_HI, TEMP_HI, 0, 0, 180, 2);
            default: begin
               // sensible ordering of thresholds with random spacing
               ce = int'($urandom_range(0, 600)) - 300;
               cl = ce + int'($urandom_range(0, 32));
               hl = cl + int'($urandom_range(0, 400));
               he = hl + int'($urandom_range(0, 32));
               configure(ce, cl, hl, he, -int'($urandom_range(0, 800)),
                         int'($urandom_range(200, 1200)),
                         $urandom_range(1, 180), $urandom_range(1, 40));
            end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // switch idle levels every stretch, sometimes to none at all
            if (n % 20 == 0) begin
               tx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
               rx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            end
            // flood the input back to back while the sink holds off
            flood_on = (ph == 1 && n < FLOOD_ITEMS);
            offer(random_item(), 1'b0, '0);
         end
         flood_on = 1'b0;
      end

      settle();
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // Hard stop in case the DUT hangs
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("tb_top: errors");
      $finish;
   end

endmodule
